@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions for the byte-stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Command codes from the front part to the compression engine.
	localparam logic [1:0] CMD_BLOCK = 2'd0; // compress, keep going
	localparam logic [1:0] CMD_FINAL = 2'd1; // compress, then emit digest

	typedef struct packed {
		logic [1:0]    cmd;
		logic [511:0]  blk;
	} job_t;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[r];
	endfunction

	localparam logic [255:0] H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ rtl/sha_front.sv @@
// ----------------------------------------------------------------------------
// SHA-256 front part
// Packs message bytes into 512-bit blocks, applies padding and length, and
// issues block jobs to the queue.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_present,
	input  logic          in_end,
	output logic          job_valid,
	input  logic          job_ready,
	output sha_pkg::job_t job
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_SLOT = 6'd56;

	logic [1:0]   state_q;
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [511:0] blk_ins;
	logic [511:0] blk_pad;
	logic [5:0]   fill_nx;
	logic         in_acc;
	logic         blk_full;

	// A byte at position p sits at bits 511-8p downward (word 0 is the top).
	always_comb begin
		blk_ins = blk_q;
		blk_ins[(10'd511 - {1'b0, fill_q, 3'b000}) -: 8] = in_byte;
		fill_nx = fill_q + 6'd1;
	end

	// Padded view of the block: bytes below the fill are kept, the marker
	// byte goes at the fill position and every byte above it is zero.
	always_comb begin
		for (int p = 0; p < 64; p++) begin
			if (6'(p) < fill_q) begin
				blk_pad[511 - 8*p -: 8] = blk_q[511 - 8*p -: 8];
			end else if (6'(p) == fill_q) begin
				blk_pad[511 - 8*p -: 8] = PAD_MARK;
			end else begin
				blk_pad[511 - 8*p -: 8] = 8'h00;
			end
		end
	end

	assign in_acc = in_valid && in_ready;
	assign blk_full = in_present && (fill_q == 6'd63);
	assign in_ready = (state_q == ST_IDLE) && job_ready;

	// Job output: a full block, a padded block or the final length block.
	always_comb begin
		job_valid = 1'b0;
		job.cmd = sha_pkg::CMD_BLOCK;
		job.blk = blk_ins;
		case (state_q)
			ST_IDLE: begin
				job_valid = in_valid && blk_full;
			end
			ST_PAD: begin
				job_valid = 1'b1;
				if (fill_q < LEN_SLOT) begin
					job.cmd = sha_pkg::CMD_FINAL;
					job.blk = {blk_pad[511:64], bits_q};
				end else begin
					job.blk = blk_pad;
				end
			end
			ST_LEN: begin
				job_valid = 1'b1;
				job.cmd = sha_pkg::CMD_FINAL;
				job.blk = {448'd0, bits_q};
			end
			default: ;
		endcase
	end

	// Fill, length and padding sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_present) begin
							fill_q <= fill_nx;
							bits_q <= bits_q + 64'd8;
						end
						if (in_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// No room for the length: it follows in a block of its own.
					if (job_ready) begin
						if (fill_q < LEN_SLOT) begin
							state_q <= ST_IDLE;
							fill_q <= '0;
							bits_q <= '0;
						end else begin
							state_q <= ST_LEN;
						end
					end
				end
				ST_LEN: begin
					if (job_ready) begin
						state_q <= ST_IDLE;
						fill_q <= '0;
						bits_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Block storage; every byte below the fill is written before it is used.
	always_ff @(posedge clk) begin
		if (in_acc && in_present) begin
			blk_q <= blk_ins;
		end
	end

endmodule

@@ rtl/sha_queue.sv @@
// ----------------------------------------------------------------------------
// SHA-256 job queue
// Small first-in first-out store of block jobs between front and engine.
// ----------------------------------------------------------------------------
module sha_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  sha_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output sha_pkg::job_t rd_job
);

	sha_pkg::job_t           mem_q [sha_pkg::QDEPTH];
	logic [sha_pkg::QAW-1:0] wp_q;
	logic [sha_pkg::QAW-1:0] rp_q;
	logic [sha_pkg::QAW:0]   cnt_q;

	assign wr_ready = cnt_q != sha_pkg::QDEPTH[sha_pkg::QAW:0];
	assign rd_valid = cnt_q != '0;
	assign rd_job = mem_q[rp_q];

	// Storage is written only, no reset needed.
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_valid && rd_ready) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{sha_pkg::QAW{1'b0}}, wr_valid && wr_ready}
				- {{sha_pkg::QAW{1'b0}}, rd_valid && rd_ready};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sha_pkg::QDEPTH[sha_pkg::QAW:0])
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !rd_valid)
		else $error("read from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && !rd_ready) |=> rd_valid)
		else $error("queue entry lost");

endmodule

@@ rtl/sha_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Runs 64 rounds, one per cycle, then adds into the chaining hash and
// streams out the digest after a final block.
// ----------------------------------------------------------------------------
module sha_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  sha_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_word,
	output logic [2:0]    out_index,
	output logic          out_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]   state_q;
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic [2:0]   oidx_q;
	logic [31:0]  wr, w_nx, s0, s1, t1, t2, x15, x2;
	logic [31:0]  a, b, c, e, f, g;

	// Message schedule and round logic; the window holds words r to r+15.
	always_comb begin
		x15 = w_q[1];
		x2 = w_q[14];
		s0 = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
		s1 = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
		wr = w_q[0];
		w_nx = w_q[0] + s0 + w_q[9] + s1;
		a = v_q[0]; b = v_q[1]; c = v_q[2];
		e = v_q[4]; f = v_q[5]; g = v_q[6];
		t1 = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
			+ ((e & f) ^ (~e & g)) + sha_pkg::round_k(rnd_q) + wr;
		t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
			+ ((a & b) ^ (a & c) ^ (b & c));
	end

	assign job_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign out_word = h_q[oidx_q];
	assign out_index = oidx_q;
	assign out_last = oidx_q == 3'd7;

	// Round sequencer; the schedule window shifts down one word a round.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			for (int i = 0; i < 16; i++) w_q[i] <= job.blk[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_nx;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			fin_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::H_INIT[32*i +: 32];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						fin_q <= job.cmd == sha_pkg::CMD_FINAL;
						rnd_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= '0;
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								h_q[i] <= sha_pkg::H_INIT[32*i +: 32];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && rnd_q == 6'd63) |=> state_q == ST_ADD)
		else $error("round count broken");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> state_q == ST_IDLE)
		else $error("digest did not end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(oidx_q))
		else $error("digest index moved while stalled");

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits eight digest words per message.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                         tuser
// s_axis    in   [7:0] data_byte               [0] byte_present; tlast end_of_message
// m_axis    out  [31:0] digest_word            [2:0] word_index; tlast last_word
//
// The front accepts bytes while idle and while the queue has room; each 64-byte
// block then goes through the round engine (load, 64 rounds, add) on the single
// round unit. An end marker makes the front emit a padded block, plus a separate
// length block when 56 or more bytes sit in the last block.
// A four-entry block queue lets the packer run while the engine works; a full
// queue stalls the input, and a stalled digest output holds the engine.
// Reset clears all control state and loads the initial hash values.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);

	logic          fj_valid, fj_ready, qj_valid, qj_ready;
	sha_pkg::job_t fj, qj;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_present(s_axis_tuser), .in_end(s_axis_tlast),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
	);

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
	);

endmodule
